// ===== hw/rtl/uhe_pkg.sv =====
// Shared types and constants for the UDP header extractor.
package uhe_pkg;

	localparam int unsigned MaxFrameBytes = 65535;
	localparam int unsigned PosW = 16;

	typedef enum logic [2:0] {
		PH_LINK = 3'd0,
		PH_VLAN = 3'd1,
		PH_MPLS = 3'd2,
		PH_IP   = 3'd3,
		PH_IP4  = 3'd4,
		PH_IP6  = 3'd5,
		PH_UDP  = 3'd6,
		PH_DONE = 3'd7
	} phase_t;

	typedef enum logic [1:0] {
		LINK_ETH  = 2'd0,
		LINK_RAW  = 2'd1,
		LINK_SLL  = 2'd2,
		LINK_LOOP = 2'd3
	} link_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_UNSUPP  = 2'd1,
		ST_NOT_UDP = 2'd2,
		ST_SHORT   = 2'd3
	} status_t;

	localparam logic [0:0] CFG_LINK_TYPE = 1'b0;
	localparam logic [0:0] CFG_LOOP_CODE = 1'b1;

	localparam logic [15:0] ETH_VLAN  = 16'h8100;
	localparam logic [15:0] ETH_MPLS  = 16'h8847;
	localparam logic [15:0] ETH_MPLSM = 16'h8848;
	localparam logic [15:0] ETH_IPV6  = 16'h86dd;
	localparam logic [15:0] ETH_IPV4  = 16'h0800;
	localparam logic [31:0] LOOP_IPV4 = 32'h0000_0002;
	localparam logic [7:0]  PROTO_UDP = 8'd17;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       frame_last;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  parse_status;
		logic        ip_version;
		logic [63:0] source_addr_hi;
		logic [63:0] source_addr_lo;
		logic [63:0] dest_addr_hi;
		logic [63:0] dest_addr_lo;
		logic [15:0] source_port;
		logic [15:0] dest_port;
		logic [15:0] payload_offset;
		logic [15:0] payload_length;
	} out_word_t;

endpackage

// ===== hw/rtl/uhe_if.sv =====
// Valid/ready stream interfaces for input bytes and parse results.
interface uhe_in_if;
	logic                 valid;
	logic                 ready;
	uhe_pkg::in_word_t    data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface uhe_out_if;
	logic                 valid;
	logic                 ready;
	uhe_pkg::out_word_t   data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/udp_header_extractor.sv =====
// Top level of the UDP header extractor: byte parser and result register.
//
// Usage: frame bytes enter on in_ch (frame_byte, frame_last), one word per
// accepted handshake. Each byte advances the header parser in the cycle it is
// accepted; at the word carrying frame_last the result is loaded into the
// output register and shown on out_ch the next cycle.
// Throughput is one byte per cycle while in_ch.ready is high.
// in_ch.ready stays high while the output register is empty or being drained
// this cycle; a stalled receiver holds back every input byte, not only a
// final one, for as long as a result is waiting, so ready drops exactly
// while out_ch.valid is high and out_ch.ready is low.
// Configuration writes (cfg_we, cfg_index, cfg_data) are registered:
// index 0 link type, index 1 loopback IPv6 family word.
// Reset (arst_n low) restores link type Ethernet, family word 10, and clears
// the frame state and the output valid flag.
module udp_header_extractor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [31:0] cfg_data,
	uhe_in_if.sink      in_ch,
	uhe_out_if.source   out_ch
);

	logic [1:0]  link_q;
	logic [31:0] loop_code_q;

	uhe_pkg::phase_t ph_q, ph_d;
	logic [15:0] pos_q, hs_q, ts_q, udp_len_q;
	logic [15:0] hs_d, ts_d, udp_len_d;
	logic [7:0]  ihl_q, ihl_d;
	logic [63:0] sa0_q, sa1_q, da0_q, da1_q, sa0_d, sa1_d, da0_d, da1_d;
	logic [31:0] pp_q, pp_d;
	logic [1:0]  st_q, st_d;

	logic        take, out_v_q;
	uhe_pkg::out_word_t res_d, res_q;
	logic [7:0]  b;
	logic [15:0] rel, len, plen, ulm8;

	// hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_q      <= uhe_pkg::LINK_ETH;
			loop_code_q <= 32'd10;
		end else if (cfg_we) begin
			if (cfg_index == uhe_pkg::CFG_LINK_TYPE) link_q <= cfg_data[1:0];
			else loop_code_q <= cfg_data;
		end
	end

	assign in_ch.ready = !out_v_q || out_ch.ready;
	assign take = in_ch.valid && in_ch.ready;
	assign b = in_ch.data.frame_byte;

	// parse one byte
	always_comb begin
		uhe_pkg::phase_t ph;
		logic [15:0] hs;
		ph = ph_q; hs = hs_q; ts_d = ts_q; ihl_d = ihl_q;
		sa0_d = sa0_q; sa1_d = sa1_q; da0_d = da0_q; da1_d = da1_q;
		pp_d = pp_q; udp_len_d = udp_len_q; st_d = st_q;
		rel = '0;
		if (pos_q != 16'(uhe_pkg::MaxFrameBytes)) begin
			if (ph == uhe_pkg::PH_LINK && link_q == uhe_pkg::LINK_RAW) begin
				ph = uhe_pkg::PH_IP;
				hs = pos_q;
			end
			if (ph == uhe_pkg::PH_IP) begin
				if (b[7:4] == 4'd4 || b[7:4] == 4'd6) begin
					ts_d = {12'd0, b[7:4]};
					ph = (b[7:4] == 4'd4) ? uhe_pkg::PH_IP4 : uhe_pkg::PH_IP6;
				end else begin
					st_d = uhe_pkg::ST_UNSUPP;
					ph = uhe_pkg::PH_DONE;
				end
			end
			rel = pos_q - hs;
			case (ph)
				uhe_pkg::PH_LINK: begin
					if (link_q == uhe_pkg::LINK_ETH) begin
						if (pos_q == 16'd12 || pos_q == 16'd13) ts_d = {ts_q[7:0], b};
						if (pos_q == 16'd13) begin
							hs = pos_q + 16'd1;
							if (ts_d == uhe_pkg::ETH_VLAN) ph = uhe_pkg::PH_VLAN;
							else if (ts_d == uhe_pkg::ETH_MPLS || ts_d == uhe_pkg::ETH_MPLSM)
								ph = uhe_pkg::PH_MPLS;
							else ph = uhe_pkg::PH_IP;
						end
					end else if (link_q == uhe_pkg::LINK_SLL) begin
						if (pos_q == 16'd14 || pos_q == 16'd15) ts_d = {ts_q[7:0], b};
						if (pos_q == 16'd15) begin
							hs = pos_q + 16'd1;
							if (ts_d == uhe_pkg::ETH_IPV4) begin
								ts_d = 16'd4; ph = uhe_pkg::PH_IP4;
							end else if (ts_d == uhe_pkg::ETH_IPV6) begin
								ts_d = 16'd6; ph = uhe_pkg::PH_IP6;
							end else begin
								hs = hs_q;
								st_d = uhe_pkg::ST_UNSUPP; ph = uhe_pkg::PH_DONE;
							end
						end
					end else begin
						if (pos_q < 16'd4) pp_d = {b, pp_q[31:8]};
						if (pos_q == 16'd3) begin
							hs = pos_q + 16'd1;
							if (pp_d == uhe_pkg::LOOP_IPV4) begin
								ts_d = 16'd4; ph = uhe_pkg::PH_IP4;
							end else if (pp_d == loop_code_q) begin
								ts_d = 16'd6; ph = uhe_pkg::PH_IP6;
							end else begin
								hs = hs_q;
								st_d = uhe_pkg::ST_UNSUPP; ph = uhe_pkg::PH_DONE;
							end
						end
					end
				end
				uhe_pkg::PH_VLAN: begin
					if (rel == 16'd2 || rel == 16'd3) ts_d = {ts_q[7:0], b};
					if (rel == 16'd3) begin
						hs = pos_q + 16'd1;
						if (ts_d == uhe_pkg::ETH_VLAN) ph = uhe_pkg::PH_VLAN;
						else if (ts_d == uhe_pkg::ETH_MPLS || ts_d == uhe_pkg::ETH_MPLSM)
							ph = uhe_pkg::PH_MPLS;
						else ph = uhe_pkg::PH_IP;
					end
				end
				uhe_pkg::PH_MPLS: begin
					if (rel == 16'd2) ts_d = {15'd0, b[0]};
					if (rel == 16'd3) begin
						hs = pos_q + 16'd1;
						if (ts_q != 16'd0) ph = uhe_pkg::PH_IP;
					end
				end
				uhe_pkg::PH_IP4: begin
					if (rel == 16'd0) begin
						ihl_d = (b[3:0] < 4'd5) ? 8'd20 : {2'd0, b[3:0], 2'd0};
					end else if (rel == 16'd9) begin
						if (b != uhe_pkg::PROTO_UDP && b != 8'd0) begin
							st_d = uhe_pkg::ST_NOT_UDP; ph = uhe_pkg::PH_DONE;
						end
					end else if (rel >= 16'd12 && rel < 16'd16) begin
						sa1_d = {sa1_q[55:0], b};
					end else if (rel >= 16'd16 && rel < 16'd20) begin
						da1_d = {da1_q[55:0], b};
					end
					if (ph == uhe_pkg::PH_IP4 && rel + 16'd1 == {8'd0, ihl_d}) begin
						ph = uhe_pkg::PH_UDP; hs = pos_q + 16'd1;
					end
				end
				uhe_pkg::PH_IP6: begin
					if (rel == 16'd0) ihl_d = 8'd40;
					else if (rel >= 16'd8 && rel < 16'd16) sa0_d = {sa0_q[55:0], b};
					else if (rel >= 16'd16 && rel < 16'd24) sa1_d = {sa1_q[55:0], b};
					else if (rel >= 16'd24 && rel < 16'd32) da0_d = {da0_q[55:0], b};
					else if (rel >= 16'd32 && rel < 16'd40) da1_d = {da1_q[55:0], b};
					if (rel == 16'd39) begin
						ph = uhe_pkg::PH_UDP; hs = pos_q + 16'd1;
					end
				end
				uhe_pkg::PH_UDP: begin
					if (rel < 16'd4) pp_d = {pp_q[23:0], b};
					else if (rel == 16'd4 || rel == 16'd5) udp_len_d = {udp_len_q[7:0], b};
					if (rel == 16'd7) begin
						hs = pos_q + 16'd1;
						st_d = uhe_pkg::ST_OK; ph = uhe_pkg::PH_DONE;
					end
				end
				default: ;
			endcase
		end
		ph_d = ph;
		hs_d = hs;
	end

	// build the result for a final byte
	always_comb begin
		len  = (pos_q != 16'(uhe_pkg::MaxFrameBytes)) ? pos_q + 16'd1 : pos_q;
		plen = len - hs_d;
		ulm8 = udp_len_d - 16'd8;
		if (ts_d == 16'd4 && udp_len_d >= 16'd8 && ulm8 < plen) plen = ulm8;
		res_d = '0;
		if (ph_d != uhe_pkg::PH_DONE) begin
			res_d.parse_status = uhe_pkg::ST_SHORT;
		end else if (st_d != uhe_pkg::ST_OK) begin
			res_d.parse_status = st_d;
		end else begin
			res_d.ip_version     = (ts_d == 16'd6);
			res_d.source_addr_hi = sa0_d;
			res_d.source_addr_lo = sa1_d;
			res_d.dest_addr_hi   = da0_d;
			res_d.dest_addr_lo   = da1_d;
			res_d.source_port    = pp_d[31:16];
			res_d.dest_port      = pp_d[15:0];
			res_d.payload_offset = hs_d;
			res_d.payload_length = plen;
		end
	end

	// advance frame state; clear at the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= uhe_pkg::PH_LINK; pos_q <= '0; hs_q <= '0; ts_q <= '0;
			ihl_q <= '0; sa0_q <= '0; sa1_q <= '0; da0_q <= '0; da1_q <= '0;
			pp_q <= '0; udp_len_q <= '0; st_q <= '0;
		end else if (take) begin
			if (in_ch.data.frame_last) begin
				ph_q <= uhe_pkg::PH_LINK; pos_q <= '0; hs_q <= '0; ts_q <= '0;
				ihl_q <= '0; sa0_q <= '0; sa1_q <= '0; da0_q <= '0; da1_q <= '0;
				pp_q <= '0; udp_len_q <= '0; st_q <= '0;
			end else begin
				ph_q <= ph_d; hs_q <= hs_d; ts_q <= ts_d; ihl_q <= ihl_d;
				sa0_q <= sa0_d; sa1_q <= sa1_d; da0_q <= da0_d; da1_q <= da1_d;
				pp_q <= pp_d; udp_len_q <= udp_len_d; st_q <= st_d;
				if (pos_q != 16'(uhe_pkg::MaxFrameBytes)) pos_q <= pos_q + 16'd1;
			end
		end
	end

	// hold the result word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (take && in_ch.data.frame_last) begin
			out_v_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && in_ch.data.frame_last) res_q <= res_d;
	end

	assign out_ch.valid = out_v_q;
	assign out_ch.data  = res_q;

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !out_ch.ready) |-> !in_ch.ready)
		else $error("input accepted while result stalled");
	a_res_load: assert property (@(posedge clk) disable iff (!arst_n)
		(take && in_ch.data.frame_last) |=> out_v_q)
		else $error("final byte did not raise result valid");
	a_frame_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(take && in_ch.data.frame_last) |=> (pos_q == 16'd0 && ph_q == uhe_pkg::PH_LINK))
		else $error("frame state not cleared after final byte");
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && res_q.parse_status != uhe_pkg::ST_OK) |-> (res_q.payload_offset == 16'd0))
		else $error("failed result carries fields");

endmodule
